### rtl/dlqm_pkg.sv
// ----------------------------------------------------------------------------
// dlqm_pkg
// Shared types and constants of the doubly linked queue manager: slot and
// link widths, operation, action and error codes, controller commands.
// ----------------------------------------------------------------------------
package dlqm_pkg;

    localparam int NODES      = 64;
    localparam int IDX_W      = 6;
    localparam int LINK_W     = 7;
    localparam int OP_W       = 3;
    localparam int ERR_W      = 2;

    localparam logic [LINK_W-1:0] NUL_LINK = LINK_W'(NODES);

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 1;

    localparam logic [OP_W-1:0] OP_ADD_HEAD   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_TAIL   = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_HEAD   = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_TAIL   = 3'd3;
    localparam logic [OP_W-1:0] OP_INS_AFTER  = 3'd4;
    localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd5;
    localparam logic [OP_W-1:0] OP_REM_NODE   = 3'd6;

    localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_LINKED   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNLINKED = 2'd2;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_LINK   = 2'd1;
    localparam logic [1:0] ACT_UNLINK = 2'd2;

    typedef struct packed {
        logic accept;
        logic own_wr;
        logic neigh_wr;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

### rtl/dlqm_ram.sv
// ----------------------------------------------------------------------------
// dlqm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dlqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/dlqm_ctrl.sv
// ----------------------------------------------------------------------------
// dlqm_ctrl
// Sequencer: accept and read, write own links, write neighbor links, load
// the result register.
// ----------------------------------------------------------------------------
module dlqm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  dlqm_pkg::t_status i_status,
    output dlqm_pkg::t_cmd    o_cmd
);
    import dlqm_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_OWN   = 2'd1;
    localparam logic [1:0] S_NEIGH = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = S_OWN;
                end
            end
            S_OWN:   n_state = S_NEIGH;
            S_NEIGH: n_state = S_DONE;
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cmd.accept    = (r_state == S_IDLE) && i_s_axis_tvalid;
    assign o_cmd.own_wr    = (r_state == S_OWN);
    assign o_cmd.neigh_wr  = (r_state == S_NEIGH);
    assign o_cmd.load_out  = (r_state == S_DONE) && i_status.out_free;

endmodule

### rtl/dlqm_dp.sv
// ----------------------------------------------------------------------------
// dlqm_dp
// Datapath: link memories, linked flags, first/last/count registers, checks
// and the result register.
// ----------------------------------------------------------------------------
module dlqm_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dlqm_pkg::t_cmd                i_cmd,
    output dlqm_pkg::t_status             o_status,
    input  logic [dlqm_pkg::OP_W-1:0]     i_operation,
    input  logic [dlqm_pkg::IDX_W-1:0]    i_node,
    input  logic [dlqm_pkg::IDX_W-1:0]    i_anchor,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [dlqm_pkg::IDX_W-1:0]    o_removed_node,
    output logic                          o_removed_valid,
    output logic                          o_list_empty,
    output logic [dlqm_pkg::LINK_W-1:0]   o_list_count,
    output logic [dlqm_pkg::ERR_W-1:0]    o_error_code
);
    import dlqm_pkg::*;

    logic [OP_W-1:0]   r_op;
    logic [IDX_W-1:0]  r_slot;
    logic [IDX_W-1:0]  r_anchor;
    logic [1:0]        r_act;
    logic [ERR_W-1:0]  r_err;
    logic [LINK_W-1:0] r_p;
    logic [LINK_W-1:0] r_q;
    logic [LINK_W-1:0] r_first;
    logic [LINK_W-1:0] r_last;
    logic [LINK_W-1:0] r_count;
    logic [NODES-1:0]  r_linked;

    logic [LINK_W-1:0] n_p;
    logic [LINK_W-1:0] n_q;
    logic [LINK_W-1:0] n_first;
    logic [LINK_W-1:0] n_last;
    logic [LINK_W-1:0] n_count;
    logic [NODES-1:0]  n_linked;
    logic [IDX_W-1:0]  n_slot;
    logic [1:0]        n_act;
    logic [ERR_W-1:0]  n_err;
    logic [IDX_W-1:0]  n_raddr;

    logic              r_ovalid;
    logic [IDX_W-1:0]  r_orem;
    logic              r_orvalid;
    logic              r_oempty;
    logic [LINK_W-1:0] r_ocount;
    logic [ERR_W-1:0]  r_oerr;

    logic [LINK_W-1:0] w_next_rd;
    logic [LINK_W-1:0] w_prev_rd;
    logic              w_next_we;
    logic [IDX_W-1:0]  w_next_waddr;
    logic [LINK_W-1:0] w_next_wdata;
    logic              w_prev_we;
    logic [IDX_W-1:0]  w_prev_waddr;
    logic [LINK_W-1:0] w_prev_wdata;
    logic              w_node_lk;
    logic              w_anchor_lk;
    logic              w_p_ok;
    logic              w_q_ok;

    // decode and check at accept
    assign w_node_lk   = r_linked[i_node];
    assign w_anchor_lk = r_linked[i_anchor];

    always_comb begin
        n_slot  = i_node;
        n_act   = ACT_NONE;
        n_err   = ERR_OK;
        n_raddr = i_node;
        case (i_operation)
            OP_ADD_HEAD, OP_ADD_TAIL: begin
                if (w_node_lk) begin
                    n_err = ERR_LINKED;
                end else begin
                    n_act = ACT_LINK;
                end
            end
            OP_REM_HEAD: begin
                n_slot  = r_first[IDX_W-1:0];
                n_raddr = r_first[IDX_W-1:0];
                if (!r_first[LINK_W-1]) begin
                    n_act = ACT_UNLINK;
                end
            end
            OP_REM_TAIL: begin
                n_slot  = r_last[IDX_W-1:0];
                n_raddr = r_last[IDX_W-1:0];
                if (!r_last[LINK_W-1]) begin
                    n_act = ACT_UNLINK;
                end
            end
            OP_INS_AFTER, OP_INS_BEFORE: begin
                n_raddr = i_anchor;
                if (w_node_lk) begin
                    n_err = ERR_LINKED;
                end else if (!w_anchor_lk) begin
                    n_err = ERR_UNLINKED;
                end else begin
                    n_act = ACT_LINK;
                end
            end
            OP_REM_NODE: begin
                if (!w_node_lk) begin
                    n_err = ERR_UNLINKED;
                end else begin
                    n_act = ACT_UNLINK;
                end
            end
            default: begin
                n_act = ACT_NONE;
            end
        endcase
    end

    // neighbors of the slot
    always_comb begin
        case (r_op)
            OP_ADD_HEAD: begin
                n_p = NUL_LINK;
                n_q = r_first;
            end
            OP_ADD_TAIL: begin
                n_p = r_last;
                n_q = NUL_LINK;
            end
            OP_INS_AFTER: begin
                n_p = {1'b0, r_anchor};
                n_q = w_next_rd;
            end
            OP_INS_BEFORE: begin
                n_p = w_prev_rd;
                n_q = {1'b0, r_anchor};
            end
            default: begin
                n_p = w_prev_rd;
                n_q = w_next_rd;
            end
        endcase
    end

    assign w_p_ok = !r_p[LINK_W-1];
    assign w_q_ok = !r_q[LINK_W-1];

    // link memory write ports
    always_comb begin
        w_next_we    = 1'b0;
        w_next_waddr = r_slot;
        w_next_wdata = n_q;
        w_prev_we    = 1'b0;
        w_prev_waddr = r_slot;
        w_prev_wdata = n_p;
        if (i_cmd.own_wr) begin
            w_next_we = (r_act == ACT_LINK);
            w_prev_we = (r_act == ACT_LINK);
        end else if (i_cmd.neigh_wr) begin
            w_next_waddr = r_p[IDX_W-1:0];
            w_prev_waddr = r_q[IDX_W-1:0];
            w_next_we    = (r_act != ACT_NONE) && w_p_ok;
            w_prev_we    = (r_act != ACT_NONE) && w_q_ok;
            if (r_act == ACT_LINK) begin
                w_next_wdata = {1'b0, r_slot};
                w_prev_wdata = {1'b0, r_slot};
            end else begin
                w_next_wdata = r_q;
                w_prev_wdata = r_p;
            end
        end
    end

    // list registers
    always_comb begin
        n_first  = r_first;
        n_last   = r_last;
        n_count  = r_count;
        n_linked = r_linked;
        if (i_cmd.neigh_wr) begin
            if (r_act == ACT_LINK) begin
                if (!w_p_ok) begin
                    n_first = {1'b0, r_slot};
                end
                if (!w_q_ok) begin
                    n_last = {1'b0, r_slot};
                end
                n_linked[r_slot] = 1'b1;
                n_count          = r_count + 1'b1;
            end else if (r_act == ACT_UNLINK) begin
                if (!w_p_ok) begin
                    n_first = r_q;
                end
                if (!w_q_ok) begin
                    n_last = r_p;
                end
                n_linked[r_slot] = 1'b0;
                n_count          = r_count - 1'b1;
            end
        end
    end

    dlqm_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_next_we),
        .i_waddr (w_next_waddr),
        .i_wdata (w_next_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (n_raddr),
        .o_rdata (w_next_rd)
    );

    dlqm_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_prev_we),
        .i_waddr (w_prev_waddr),
        .i_wdata (w_prev_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (n_raddr),
        .o_rdata (w_prev_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_operation;
            r_slot   <= n_slot;
            r_anchor <= i_anchor;
            r_act    <= n_act;
            r_err    <= n_err;
        end
        if (i_cmd.own_wr) begin
            r_p <= n_p;
            r_q <= n_q;
        end
        if (i_cmd.load_out) begin
            r_orem    <= (r_act == ACT_UNLINK) ? r_slot : '0;
            r_orvalid <= (r_act == ACT_UNLINK);
            r_oempty  <= (r_count == '0);
            r_ocount  <= r_count;
            r_oerr    <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= NUL_LINK;
            r_last   <= NUL_LINK;
            r_count  <= '0;
            r_linked <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_first  <= n_first;
            r_last   <= n_last;
            r_count  <= n_count;
            r_linked <= n_linked;
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = !r_ovalid || i_m_tready;
    assign o_m_tvalid        = r_ovalid;
    assign o_removed_node    = r_orem;
    assign o_removed_valid   = r_orvalid;
    assign o_list_empty      = r_oempty;
    assign o_list_count      = r_ocount;
    assign o_error_code      = r_oerr;

    a_count_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == LINK_W'($countones(r_linked)))
        else $error("count differs from number of linked slots");

    a_ends_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_first == NUL_LINK) == (r_last == NUL_LINK))
        else $error("first and last disagree on emptiness");

    a_empty_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_first == NUL_LINK))
        else $error("count and first disagree on emptiness");

    a_unlink_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.neigh_wr && (r_act == ACT_UNLINK)) |=> !r_linked[$past(r_slot)])
        else $error("removed slot still flagged as linked");

endmodule

### rtl/doubly_linked_queue_manager.sv
// ----------------------------------------------------------------------------
// doubly_linked_queue_manager
// One ordered doubly linked list over a pool of node slots.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the operation (add head, add tail, remove
// head, remove tail, insert after, insert before, remove node), tdata the
// node and anchor slots. Each item gives one result item: removed slot and
// its valid flag, emptiness, count and error code.
// An item goes through accept with link read, own link write, neighbor
// link write and result load. Next and previous links sit in two RAMs with
// one write port each, and an insert touches two entries of each, so own
// and neighbor links are written in separate steps. The block takes no new
// item until the result of the last one is loaded; the next item is taken
// in the cycle after that load.
// Reset empties the list: first and last go to the null code, count and all
// linked flags to zero; the link RAMs are not cleared.
// When the receiver stalls, the result holds in the output register, the
// block accepts and works on one more item, then waits with it until the
// output register frees.
// ----------------------------------------------------------------------------
module doubly_linked_queue_manager (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // node[5:0], anchor[11:6], zero[15:12]
    input  logic [dlqm_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // operation[2:0]
    input  logic [dlqm_pkg::IN_USER_W-1:0]      i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // removed_node[5:0], list_empty[6], list_count[13:7], error_code[15:14]
    output logic [dlqm_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // removed_valid[0]
    output logic [dlqm_pkg::OUT_USER_W-1:0]     o_m_axis_tuser
);
    import dlqm_pkg::*;

    t_cmd              w_cmd;
    t_status           w_status;
    logic [IDX_W-1:0]  w_removed_node;
    logic              w_removed_valid;
    logic              w_list_empty;
    logic [LINK_W-1:0] w_list_count;
    logic [ERR_W-1:0]  w_error_code;

    dlqm_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (w_status),
        .o_cmd           (w_cmd)
    );

    dlqm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_operation     (i_s_axis_tuser[OP_W-1:0]),
        .i_node          (i_s_axis_tdata[IDX_W-1:0]),
        .i_anchor        (i_s_axis_tdata[2*IDX_W-1:IDX_W]),
        .i_m_tready      (i_m_axis_tready),
        .o_m_tvalid      (o_m_axis_tvalid),
        .o_removed_node  (w_removed_node),
        .o_removed_valid (w_removed_valid),
        .o_list_empty    (w_list_empty),
        .o_list_count    (w_list_count),
        .o_error_code    (w_error_code)
    );

    assign o_m_axis_tdata = {w_error_code, w_list_count, w_list_empty, w_removed_node};
    assign o_m_axis_tuser = w_removed_valid;

endmodule
